FILE: rtl/rrtt_pkg.sv
// ---------------------------------------------------------------------------
// rrtt_pkg
// Shared types and constants of the retransmit request throttle table.
// ---------------------------------------------------------------------------
package rrtt_pkg;

    localparam int TABLE_DEPTH = 64;

    localparam logic [2:0] KIND_CHECK       = 3'd0;
    localparam logic [2:0] KIND_REMEMBER    = 3'd1;
    localparam logic [2:0] KIND_FORGET_SESS = 3'd2;
    localparam logic [2:0] KIND_FORGET_STRM = 3'd3;
    localparam logic [2:0] KIND_CLEAR       = 3'd4;

    localparam logic [1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_MAX_ENTRIES  = 2'd1;
    localparam logic [1:0] CFG_MAX_AGE      = 2'd2;

    // One table entry: the retransmit key and the time it was last resent.
    typedef struct packed {
        logic [47:0] last_sent;
        logic [32:0] seqs_rtx;
        logic [31:0] cache_ssrc;
        logic [31:0] fb_ssrc;
        logic [31:0] session;
        logic [31:0] stream;
    } entry_t;

endpackage

FILE: rtl/rrtt_ram.sv
// ---------------------------------------------------------------------------
// rrtt_ram
// Entry store: one write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module rrtt_ram #(
    parameter int DEPTH = rrtt_pkg::TABLE_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  rrtt_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output rrtt_pkg::entry_t rdata
);

    rrtt_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/retransmit_request_throttle_table_top.sv
// ---------------------------------------------------------------------------
// retransmit_request_throttle_table_top
// Throttle table for retransmit requests, held in a one-port-read entry store.
// ---------------------------------------------------------------------------
// Sequence: check and forget make one pass over the entry store at one entry a cycle,
// and check then compares the time of a match; remember makes the same pass, then updates
// the match or evicts the oldest and inserts, and trims one entry a cycle.
// Invalid keys, clear and unused kinds go straight to the result stage.
// One request at a time: the next request is taken once the result is queued.
// Reset clears all valid bits, the count and the control registers at once; no clearing pass.
module retransmit_request_throttle_table_top #(
    parameter int TABLE_DEPTH = rrtt_pkg::TABLE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    // Request stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata, lowest bit up: stream_tag, session_tag, feedback_ssrc, cached_ssrc,
    // feedback_seq, cached_seq, rtx_flag, now_ms, zero fill.
    input  logic [215:0] s_tdata,
    // tuser: kind.
    input  logic [2:0]   s_tuser,
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata, lowest bit up: allowed, elapsed_ms, wait_ms, last_sent_ms, entry_count.
    output logic [135:0] m_tdata,
    // Configuration writes.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SCAN   = 9'b000000010,
        ST_UPDATE = 9'b000000100,
        ST_EVICT  = 9'b000001000,
        ST_INSERT = 9'b000010000,
        ST_TRIM   = 9'b000100000,
        ST_CALC   = 9'b001000000,
        ST_CMP    = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [31:0] min_int_reg, min_int_next;
    logic [6:0]  max_ent_reg, max_ent_next;
    logic [31:0] max_age_reg, max_age_next;

    // The request being worked on. The key travels with now_ms in the time field,
    // which is exactly the entry written on a remember.
    rrtt_pkg::entry_t it_reg, it_next;
    logic [2:0]       kind_reg, kind_next;

    // Slot bookkeeping in flip-flops: valid bits, insertion ranks and the count.
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [AW-1:0]          rank_reg [TABLE_DEPTH];
    logic [AW-1:0]          rank_next [TABLE_DEPTH];
    logic [CW-1:0]          cnt_reg, cnt_next;

    // Scan pointer and the read stage behind the store.
    logic [AW-1:0] iss_reg, iss_next;
    logic          iss_done_reg, iss_done_next;
    logic          s1_vld_reg, s1_vld_next;
    logic [AW-1:0] s1_idx_reg, s1_idx_next;

    // Match found in the scan.
    logic          hit_reg, hit_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic [47:0]   hit_last_reg, hit_last_next;

    // Result fields being built.
    logic        allowed_reg, allowed_next;
    logic [47:0] elapsed_reg, elapsed_next;
    logic [31:0] wait_reg, wait_next;
    logic [47:0] last_reg, last_next;

    // Result register towards the output.
    logic         m_vld_reg, m_vld_next;
    logic [135:0] m_data_reg, m_data_next;

    // Entry store ports.
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    rrtt_pkg::entry_t mem_rd;

    // Helpers.
    rrtt_pkg::entry_t       in_ent;
    logic [2:0]             in_kind;
    logic                   in_key_ok;
    logic [TABLE_DEPTH-1:0] drop_vec;
    logic [AW-1:0]          drop_rank;
    logic [TABLE_DEPTH-1:0] oldest_vec;
    logic [TABLE_DEPTH-1:0] free_vec;
    logic [TABLE_DEPTH-1:0] free_oh;
    logic                   any_free;
    logic [AW-1:0]          free_idx;
    logic [31:0]            cnt32;
    logic [31:0]            me32;
    logic [31:0]            cap32;
    logic                   trim_need;
    logic                   table_full;
    logic                   s1_valid_bit;
    logic [47:0]            age_diff;
    logic                   s1_expired;
    logic                   s1_match;
    logic                   s1_tag_hit;
    logic                   in_accept;

    rrtt_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_wa),
        .wdata (it_reg),
        .raddr (iss_reg),
        .rdata (mem_rd)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_vld_reg;
    assign m_tdata   = m_data_reg;
    assign in_accept = s_tvalid && s_tready;

    // Unpack an incoming request.
    always_comb
    begin
        in_ent.stream     = s_tdata[31:0];
        in_ent.session    = s_tdata[63:32];
        in_ent.fb_ssrc    = s_tdata[95:64];
        in_ent.cache_ssrc = s_tdata[127:96];
        in_ent.seqs_rtx   = {s_tdata[143:128], s_tdata[159:144], s_tdata[160]};
        in_ent.last_sent  = s_tdata[208:161];
        in_kind           = s_tuser;
        in_key_ok = (in_ent.stream != 32'd0) && (in_ent.session != 32'd0) &&
                    (in_ent.fb_ssrc != 32'd0) && (in_ent.cache_ssrc != 32'd0);
    end

    // Capacity and occupancy; an entry limit above the depth acts as the depth.
    always_comb
    begin
        cnt32      = 32'(cnt_reg);
        me32       = {25'd0, max_ent_reg};
        cap32      = (me32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : me32;
        trim_need  = cnt32 > cap32;
        table_full = cnt32 >= 32'(TABLE_DEPTH);
    end

    // Oldest entry (rank zero) and lowest free slot.
    always_comb
    begin
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            oldest_vec[j] = valid_reg[j] && (rank_reg[j] == '0);
        end
        free_vec = ~valid_reg;
        free_oh  = free_vec & (~free_vec + 1'b1);
        any_free = |free_vec;
        free_idx = '0;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            if (free_oh[j])
            begin
                free_idx = free_idx | AW'(j);
            end
        end
    end

    // Checks on the entry coming out of the store during a scan.
    always_comb
    begin
        s1_valid_bit = valid_reg[s1_idx_reg];
        age_diff     = it_reg.last_sent - mem_rd.last_sent;
        s1_expired   = (max_age_reg != 32'd0) && s1_valid_bit &&
                       (mem_rd.last_sent != 48'd0) &&
                       (it_reg.last_sent > mem_rd.last_sent) &&
                       (age_diff > {16'd0, max_age_reg});
        s1_match     = s1_valid_bit &&
                       (mem_rd.stream == it_reg.stream) &&
                       (mem_rd.session == it_reg.session) &&
                       (mem_rd.fb_ssrc == it_reg.fb_ssrc) &&
                       (mem_rd.cache_ssrc == it_reg.cache_ssrc) &&
                       (mem_rd.seqs_rtx == it_reg.seqs_rtx);
        if (kind_reg == rrtt_pkg::KIND_FORGET_SESS)
        begin
            s1_tag_hit = s1_valid_bit && (mem_rd.session == it_reg.session);
        end
        else
        begin
            s1_tag_hit = s1_valid_bit && (mem_rd.stream == it_reg.stream);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        min_int_next  = min_int_reg;
        max_ent_next  = max_ent_reg;
        max_age_next  = max_age_reg;
        it_next       = it_reg;
        kind_next     = kind_reg;
        iss_next      = iss_reg;
        iss_done_next = iss_done_reg;
        s1_vld_next   = 1'b0;
        s1_idx_next   = iss_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_last_next = hit_last_reg;
        allowed_next  = allowed_reg;
        elapsed_next  = elapsed_reg;
        wait_next     = wait_reg;
        last_next     = last_reg;
        m_vld_next    = m_vld_reg;
        m_data_next   = m_data_reg;
        drop_vec      = '0;
        mem_we        = 1'b0;
        mem_wa        = hit_idx_reg;
        valid_next    = valid_reg;
        cnt_next      = cnt_reg;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            rank_next[j] = rank_reg[j];
        end

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rrtt_pkg::CFG_MIN_INTERVAL: min_int_next = cfg_data;
                rrtt_pkg::CFG_MAX_ENTRIES:  max_ent_next = cfg_data[6:0];
                rrtt_pkg::CFG_MAX_AGE:      max_age_next = cfg_data;
                default: ;
            endcase
        end

        if (m_vld_reg && m_tready)
        begin
            m_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    it_next       = in_ent;
                    kind_next     = in_kind;
                    iss_next      = '0;
                    iss_done_next = 1'b0;
                    hit_next      = 1'b0;
                    allowed_next  = 1'b1;
                    elapsed_next  = '0;
                    wait_next     = '0;
                    last_next     = '0;
                    state_next    = ST_FINISH;
                    if (((in_kind == rrtt_pkg::KIND_CHECK && min_int_reg != 32'd0) ||
                         in_kind == rrtt_pkg::KIND_REMEMBER) &&
                        in_key_ok && max_ent_reg != 7'd0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if ((in_kind == rrtt_pkg::KIND_FORGET_SESS &&
                              in_ent.session != 32'd0) ||
                             (in_kind == rrtt_pkg::KIND_FORGET_STRM &&
                              in_ent.stream != 32'd0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (in_kind == rrtt_pkg::KIND_CLEAR)
                    begin
                        valid_next = '0;
                        cnt_next   = '0;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!iss_done_reg)
                begin
                    s1_vld_next = 1'b1;
                    if (iss_reg == AW'(TABLE_DEPTH - 1))
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        iss_next = iss_reg + 1'b1;
                    end
                end
                if (s1_vld_reg)
                begin
                    if (kind_reg == rrtt_pkg::KIND_CHECK ||
                        kind_reg == rrtt_pkg::KIND_REMEMBER)
                    begin
                        if (s1_expired)
                        begin
                            drop_vec[s1_idx_reg] = 1'b1;
                        end
                        else if (s1_match && !hit_reg)
                        begin
                            hit_next      = 1'b1;
                            hit_idx_next  = s1_idx_reg;
                            hit_last_next = mem_rd.last_sent;
                        end
                    end
                    else if (s1_tag_hit)
                    begin
                        drop_vec[s1_idx_reg] = 1'b1;
                    end
                end
                if (iss_done_reg && !s1_vld_reg)
                begin
                    if (kind_reg == rrtt_pkg::KIND_CHECK)
                    begin
                        state_next = hit_reg ? ST_CALC : ST_FINISH;
                    end
                    else if (kind_reg == rrtt_pkg::KIND_REMEMBER)
                    begin
                        if (hit_reg)
                        begin
                            state_next = ST_UPDATE;
                        end
                        else
                        begin
                            state_next = table_full ? ST_EVICT : ST_INSERT;
                        end
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_UPDATE:
            begin
                mem_we     = 1'b1;
                mem_wa     = hit_idx_reg;
                state_next = ST_TRIM;
            end

            ST_EVICT:
            begin
                drop_vec   = oldest_vec;
                state_next = ST_INSERT;
            end

            ST_INSERT:
            begin
                if (any_free)
                begin
                    mem_we               = 1'b1;
                    mem_wa               = free_idx;
                    valid_next[free_idx] = 1'b1;
                    rank_next[free_idx]  = AW'(cnt_reg);
                    cnt_next             = cnt_reg + 1'b1;
                end
                state_next = ST_TRIM;
            end

            ST_TRIM:
            begin
                if (trim_need)
                begin
                    drop_vec = oldest_vec;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_CALC:
            begin
                last_next = hit_last_reg;
                if (it_reg.last_sent <= hit_last_reg)
                begin
                    allowed_next = 1'b0;
                    wait_next    = min_int_reg;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    elapsed_next = it_reg.last_sent - hit_last_reg;
                    state_next   = ST_CMP;
                end
            end

            ST_CMP:
            begin
                if (elapsed_reg < {16'd0, min_int_reg})
                begin
                    allowed_next = 1'b0;
                    wait_next    = min_int_reg - elapsed_reg[31:0];
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!m_vld_reg || m_tready)
                begin
                    m_vld_next  = 1'b1;
                    m_data_next = {7'(cnt_reg), last_reg, wait_reg, elapsed_reg, allowed_reg};
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Dropping a slot closes the gap in the insertion order behind it.
        drop_rank = '0;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            if (drop_vec[j])
            begin
                drop_rank = drop_rank | rank_reg[j];
            end
        end
        if (|drop_vec)
        begin
            for (int j = 0; j < TABLE_DEPTH; j++)
            begin
                if (drop_vec[j])
                begin
                    valid_next[j] = 1'b0;
                end
                else if (valid_reg[j] && rank_reg[j] > drop_rank)
                begin
                    rank_next[j] = rank_reg[j] - 1'b1;
                end
            end
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            min_int_reg  <= 32'd0;
            max_ent_reg  <= 7'd64;
            max_age_reg  <= 32'd0;
            valid_reg    <= '0;
            cnt_reg      <= '0;
            iss_done_reg <= 1'b1;
            s1_vld_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            m_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            min_int_reg  <= min_int_next;
            max_ent_reg  <= max_ent_next;
            max_age_reg  <= max_age_next;
            valid_reg    <= valid_next;
            cnt_reg      <= cnt_next;
            iss_done_reg <= iss_done_next;
            s1_vld_reg   <= s1_vld_next;
            hit_reg      <= hit_next;
            m_vld_reg    <= m_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        it_reg       <= it_next;
        kind_reg     <= kind_next;
        iss_reg      <= iss_next;
        s1_idx_reg   <= s1_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_last_reg <= hit_last_next;
        allowed_reg  <= allowed_next;
        elapsed_reg  <= elapsed_next;
        wait_reg     <= wait_next;
        last_reg     <= last_next;
        m_data_reg   <= m_data_next;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            rank_reg[j] <= rank_next[j];
        end
    end

`ifndef SYNTH
    // The count always agrees with the number of valid slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(cnt_reg))
        else $error("entry count differs from valid slots");

    // The count never exceeds the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= 32'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A request once taken leaves s_tready low in the cycle after.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");
`endif

endmodule
